// ===== sv/btint_pkg.sv =====
package btint_pkg;

  typedef struct packed {
    logic              op;
    logic [5:0]        point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic [1:0] interp_mode;
    logic       bounds_mode;
    logic [6:0] point_count;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic       accept;
    logic [1:0] rd_sel;
    logic       cap_lo;
    logic       bnd_eval;
    logic       scan_start;
    logic       scan_step;
    logic       mod_fix;
    logic       div_mod;
    logic       div_frac;
    logic       res_sel;
    logic       mul_lo;
    logic       mul_hi;
    logic       mul_sum;
    logic       lerp_fin;
    logic       out_load;
    logic       out_query;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic wrap_go;
    logic div_busy;
    logic scan_done;
    logic need_lerp;
    logic out_busy;
  } sts_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic STATUS_WRITE_ACK = 1'b0;
  localparam logic STATUS_QUERY     = 1'b1;

  localparam logic [1:0] IMODE_LINEAR  = 2'd0;
  localparam logic [1:0] IMODE_NEAREST = 2'd1;
  localparam logic [1:0] IMODE_LOWER   = 2'd2;

  localparam logic BMODE_CLAMP = 1'b0;
  localparam logic BMODE_WRAP  = 1'b1;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_INTERP = 2'd0;
  localparam logic [1:0] REG_BOUNDS = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_LAST = 2'd1;
  localparam logic [1:0] RD_SCAN = 2'd2;

  localparam logic [5:0] DIV_STEPS_MOD  = 6'd33;
  localparam logic [5:0] DIV_STEPS_FRAC = 6'd31;

  localparam logic [1:0] INTERP_RESET = IMODE_LINEAR;
  localparam logic       BOUNDS_RESET = BMODE_CLAMP;
  localparam logic [6:0] COUNT_RESET  = 7'd2;

endpackage

// ===== sv/breakpoint_table_interpolator_core.sv =====
// Breakpoint table interpolator.
// Input channel (in_valid/in_ready/in_data): a write transaction stores one
// breakpoint (x, y) in a slot; a query transaction looks up an x value. Every
// input transaction yields exactly one output transaction on out_valid/out_ready:
// zero with status clear for a write, the looked-up y with status set for a query.
// Settings come through the APB port: interp_mode at 0x0, bounds_mode at 0x4,
// point_count at 0x8; change them only while the block is idle.
// One transaction is worked at a time. A write is acknowledged once the
// output register is free. A query reads x[0] and x[n-1], checks the bounds,
// wraps x over the span through the divider when needed, scans the table
// serially until the search stops, and divides and multiplies for linear
// interpolation; the scan and the shared bit-serial divider set its pace.
// A finished result waits in the output register while the next transaction
// is accepted and worked; a stalled receiver holds that one before output.
// Reset clears the settings to linear, clamp and two points; table contents
// are not cleared, and a query must only touch written slots.
module breakpoint_table_interpolator_core #(
  parameter int MAX_POINTS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  btint_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output btint_pkg::out_item_t             out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [btint_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  btint_pkg::cfg_t cfg;
  btint_pkg::cmd_t cmd;
  btint_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interp_mode <= btint_pkg::INTERP_RESET;
      cfg.bounds_mode <= btint_pkg::BOUNDS_RESET;
      cfg.point_count <= btint_pkg::COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        btint_pkg::REG_INTERP: cfg.interp_mode <= pwdata[1:0];
        btint_pkg::REG_BOUNDS: cfg.bounds_mode <= pwdata[0];
        btint_pkg::REG_COUNT:  cfg.point_count <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      btint_pkg::REG_INTERP: prdata = {30'd0, cfg.interp_mode};
      btint_pkg::REG_BOUNDS: prdata = {31'd0, cfg.bounds_mode};
      btint_pkg::REG_COUNT:  prdata = {25'd0, cfg.point_count};
      default:               prdata = 32'd0;
    endcase
  end

  btint_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  btint_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/btint_div.sv =====
module btint_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [5:0]  steps,
  input  logic [33:0] rem_init,
  input  logic [32:0] dvd_init,
  input  logic [32:0] den,
  output logic        busy,
  output logic [32:0] quo,
  output logic [33:0] rem
);

  logic        active;
  logic [5:0]  cnt;
  logic [32:0] dvd;
  logic [32:0] den_r;
  logic [33:0] trial;
  logic        ge;

  // restoring step: shift one dividend bit into the partial remainder
  assign trial = {rem[32:0], dvd[32]};
  assign ge    = trial >= {1'b0, den_r};
  assign busy  = active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (load) begin
      active <= 1'b1;
      cnt    <= steps;
    end else if (active) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= rem_init;
      dvd   <= dvd_init;
      den_r <= den;
      quo   <= '0;
    end else if (active) begin
      rem <= ge ? (trial - {1'b0, den_r}) : trial;
      dvd <= {dvd[31:0], 1'b0};
      quo <= {quo[31:0], ge};
    end
  end

endmodule

// ===== sv/btint_ctrl.sv =====
module btint_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  btint_pkg::sts_t   sts,
  output btint_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WACK = 4'd1;
  localparam logic [3:0] S_RD0  = 4'd2;
  localparam logic [3:0] S_RDN  = 4'd3;
  localparam logic [3:0] S_BND  = 4'd4;
  localparam logic [3:0] S_MOD  = 4'd5;
  localparam logic [3:0] S_FIX  = 4'd6;
  localparam logic [3:0] S_SCAN = 4'd7;
  localparam logic [3:0] S_SEL  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_MUL1 = 4'd10;
  localparam logic [3:0] S_MUL2 = 4'd11;
  localparam logic [3:0] S_SUM  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = (in_op == btint_pkg::OP_QUERY) ? S_RD0 : S_WACK;
        end
      end
      S_WACK: begin
        if (!sts.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.out_query = 1'b0;
          state_next    = S_IDLE;
        end
      end
      S_RD0: begin
        cmd.rd_sel = btint_pkg::RD_ZERO;
        state_next = S_RDN;
      end
      S_RDN: begin
        cmd.rd_sel = btint_pkg::RD_LAST;
        cmd.cap_lo = 1'b1;
        state_next = S_BND;
      end
      S_BND: begin
        cmd.bnd_eval = 1'b1;
        if (sts.wrap_go) begin
          cmd.div_mod = 1'b1;
          state_next  = S_MOD;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_MOD: begin
        if (!sts.div_busy) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.mod_fix    = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_sel    = btint_pkg::RD_SCAN;
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        if (sts.need_lerp) begin
          cmd.div_frac = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.res_sel = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_hi = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.mul_sum = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        cmd.lerp_fin = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.out_query = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/btint_dp.sv =====
module btint_dp #(
  parameter int MAX_POINTS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  btint_pkg::cfg_t       cfg,
  input  btint_pkg::cmd_t       cmd,
  output btint_pkg::sts_t       sts,
  input  btint_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output btint_pkg::out_item_t  out_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
  localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

  // breakpoint store
  logic [31:0] mem_x [MAX_POINTS];
  logic [31:0] mem_y [MAX_POINTS];
  logic [AW-1:0] waddr;
  logic          wr_ok;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_x;
  logic [31:0]   rd_y;

  logic [31:0]   q;
  logic [31:0]   lo;
  logic [32:0]   span;
  logic          neg;
  logic [AW-1:0] n_last;
  logic [31:0]   pc_w;

  logic [AW-1:0] scan_k;
  logic [AW-1:0] rd_idx;
  logic          rd_vld;
  logic          scan_ge;
  logic          scan_term;
  logic [31:0]   prev_x;
  logic [31:0]   prev_y;
  logic [31:0]   cur_x;
  logic [31:0]   cur_y;
  logic          found;
  logic          exact;
  logic          first;

  logic          below;
  logic          above;
  logic [32:0]   span_w;
  logic [32:0]   d_w;
  logic [32:0]   d_mag;
  logic          wrap_ok;
  logic [33:0]   r_fix;

  logic          div_load;
  logic [5:0]    div_steps;
  logic [33:0]   div_rem_init;
  logic [32:0]   div_dvd_init;
  logic [32:0]   div_den;
  logic          div_busy;
  logic [32:0]   div_quo;
  logic [33:0]   div_rem;

  logic [32:0]   dl;
  logic [32:0]   dh;
  logic [32:0]   dy;
  logic [32:0]   mag;
  logic [16:0]   mul_a;
  logic [47:0]   mul_p;
  logic [47:0]   p_lo;
  logic [47:0]   p_hi;
  logic [63:0]   prod;
  logic [32:0]   rsum;
  logic [34:0]   fin_v;
  logic [31:0]   pick_y;
  logic [31:0]   res;

  assign pc_w  = 32'(cfg.point_count);
  assign wr_ok = 32'(in_data.point_index) < 32'(MAX_POINTS);
  assign waddr = AW'(32'(in_data.point_index));

  always_comb begin
    case (cmd.rd_sel)
      btint_pkg::RD_ZERO: rd_addr = '0;
      btint_pkg::RD_LAST: rd_addr = n_last;
      btint_pkg::RD_SCAN: rd_addr = scan_k;
      default:            rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.op == btint_pkg::OP_WRITE && wr_ok) begin
      mem_x[waddr] <= in_data.x_value;
      mem_y[waddr] <= in_data.y_value;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  // range check against x[0] (lo) and x[n-1] (rd_x while evaluating bounds)
  assign below   = $signed(q) < $signed(lo);
  assign above   = $signed(q) > $signed(rd_x);
  assign span_w  = {rd_x[31], rd_x} - {lo[31], lo};
  assign wrap_ok = (cfg.bounds_mode == btint_pkg::BMODE_WRAP) && !span_w[32] && (span_w != '0);
  assign d_w     = {q[31], q} - {lo[31], lo};
  assign d_mag   = d_w[32] ? (33'd0 - d_w) : d_w;
  // truncating remainder brought to the nonnegative one
  assign r_fix   = (neg && div_rem != '0) ? ({1'b0, span} - div_rem) : div_rem;

  assign sts.wrap_go = (below || above) && wrap_ok;

  // scan compare, one entry per cycle behind the read
  assign scan_ge   = $signed(rd_x) >= $signed(q);
  assign scan_term = rd_vld && (scan_ge || rd_idx == n_last);
  assign sts.scan_done = scan_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_k <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_k <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_k <= scan_k + 1'b1;
      rd_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q <= in_data.x_value;
      if (pc_w < 32'd2) begin
        n_last <= AW'(1);
      end else if (pc_w > 32'(MAX_POINTS)) begin
        n_last <= AW'(MAX_POINTS - 1);
      end else begin
        n_last <= AW'(pc_w - 32'd1);
      end
    end
    if (cmd.cap_lo) begin
      lo <= rd_x;
    end
    if (cmd.bnd_eval) begin
      span <= span_w;
      neg  <= d_w[32];
      if (!sts.wrap_go) begin
        if (below) begin
          q <= lo;
        end else if (above) begin
          q <= rd_x;
        end
      end
    end
    if (cmd.mod_fix) begin
      q <= 32'({{2{lo[31]}}, lo} + r_fix);
    end
    if (cmd.scan_step) begin
      rd_idx <= scan_k;
      if (scan_term) begin
        cur_x <= rd_x;
        cur_y <= rd_y;
        found <= scan_ge;
        exact <= rd_x == q;
        first <= rd_idx == '0;
      end else if (rd_vld) begin
        prev_x <= rd_x;
        prev_y <= rd_y;
      end
    end
  end

  // shared divider: wrap remainder, then interpolation fraction
  assign div_load     = cmd.div_mod || cmd.div_frac;
  assign div_steps    = cmd.div_mod ? btint_pkg::DIV_STEPS_MOD : btint_pkg::DIV_STEPS_FRAC;
  assign div_rem_init = cmd.div_mod ? 34'd0 : {1'b0, dl};
  assign div_dvd_init = cmd.div_mod ? d_mag : 33'd0;
  assign div_den      = cmd.div_mod ? span_w : ({cur_x[31], cur_x} - {prev_x[31], prev_x});
  assign sts.div_busy = div_busy;

  btint_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .steps    (div_steps),
    .rem_init (div_rem_init),
    .dvd_init (div_dvd_init),
    .den      (div_den),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign dl = {q[31], q} - {prev_x[31], prev_x};
  assign dh = {cur_x[31], cur_x} - {q[31], q};
  assign sts.need_lerp = found && !exact && !first &&
                         (cfg.interp_mode == btint_pkg::IMODE_LINEAR);

  always_comb begin
    if (!found || exact || first) begin
      pick_y = cur_y;
    end else if (cfg.interp_mode == btint_pkg::IMODE_NEAREST) begin
      pick_y = ($signed(dl) <= $signed(dh)) ? prev_y : cur_y;
    end else begin
      pick_y = prev_y;
    end
  end

  // |dy| * f split into two partial products, low half then high half of |dy|
  assign dy    = {cur_y[31], cur_y} - {prev_y[31], prev_y};
  assign mag   = dy[32] ? (33'd0 - dy) : dy;
  assign mul_a = cmd.mul_hi ? {1'b0, mag[32:17]} : mag[16:0];
  assign mul_p = 48'(div_quo[30:0]) * 48'(mul_a);
  assign prod  = {16'd0, p_lo} + {p_hi[46:0], 17'd0} + 64'h0000_0000_4000_0000;
  assign fin_v = dy[32] ? ({{3{prev_y[31]}}, prev_y} - {2'b0, rsum})
                        : ({{3{prev_y[31]}}, prev_y} + {2'b0, rsum});

  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      p_lo <= mul_p;
    end
    if (cmd.mul_hi) begin
      p_hi <= mul_p;
    end
    if (cmd.mul_sum) begin
      rsum <= prod[63:31];
    end
    if (cmd.res_sel) begin
      res <= pick_y;
    end else if (cmd.lerp_fin) begin
      if ($signed(fin_v) > SAT_HI) begin
        res <= SAT_HI[31:0];
      end else if ($signed(fin_v) < SAT_LO) begin
        res <= SAT_LO[31:0];
      end else begin
        res <= fin_v[31:0];
      end
    end
  end

  // result register
  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.result_value <= cmd.out_query ? res : 32'd0;
      out_data.status       <= cmd.out_query ? btint_pkg::STATUS_QUERY
                                             : btint_pkg::STATUS_WRITE_ACK;
    end
  end

endmodule

// ===== tb/sv/tb_breakpoint_table_interpolator_core.sv =====
module tb_breakpoint_table_interpolator_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int END_WAIT = 150;
  localparam int PHASES = 12;
  localparam int RANDOM_PER_PHASE = 85;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint Q_ONE = 64'sh1_0000;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S32_MAX = 64'sd2147483647;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  btint_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  btint_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [btint_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  breakpoint_table_interpolator_core u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predictor state
  logic signed [31:0] bp_x [MAX_PTS];
  logic signed [31:0] bp_y [MAX_PTS];
  logic [1:0] cfg_interp = btint_pkg::INTERP_RESET;
  logic cfg_bounds = btint_pkg::BOUNDS_RESET;
  logic [6:0] cfg_count = btint_pkg::COUNT_RESET;

  // stimulus-side view of the table, updated as writes are queued
  longint plan_x [MAX_PTS];

  btint_pkg::in_item_t queued_items [$];
  btint_pkg::out_item_t awaited_answers [$];
  int items_queued = 0;
  int results_seen = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_grants = 0;
  int hold_left = 0;
  logic in_taken = 1'b0;
  logic drv_valid;
  btint_pkg::in_item_t drv_item;
  btint_pkg::out_item_t want;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic signed [31:0] clip32(longint v);
    if (v > S32_MAX) return S32_MAX[31:0];
    if (v < S32_MIN) return S32_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] lerp_y(longint q, longint xlo, longint xhi,
                                                 longint ylo, longint yhi);
    logic [63:0] num, den, frac, mag, rnd;
    longint dy;
    num = q - xlo;
    den = xhi - xlo;
    if (den == 0 || num >= den) return clip32(ylo);
    frac = (num << 31) / den;
    dy = yhi - ylo;
    mag = (dy < 0) ? -dy : dy;
    // round half away from zero on the magnitude
    rnd = (mag * frac + (64'd1 << 30)) >> 31;
    return clip32((dy < 0) ? ylo - $signed(rnd) : ylo + $signed(rnd));
  endfunction

  function automatic logic signed [31:0] table_lookup(longint q_in);
    int n, i;
    longint q, lo, hi, span, r, xlo, xhi;
    q = q_in;
    n = cfg_count;
    if (n < 2) n = 2;
    if (n > MAX_PTS) n = MAX_PTS;
    lo = bp_x[0];
    hi = bp_x[n-1];
    if (q < lo || q > hi) begin
      span = hi - lo;
      if (cfg_bounds == btint_pkg::BMODE_WRAP && span > 0) begin
        r = (q - lo) % span;
        if (r < 0) r += span;
        q = lo + r;
      end else begin
        q = (q < lo) ? lo : hi;
      end
    end
    i = 0;
    while (i < n && q > bp_x[i]) i++;
    if (i >= n) return bp_y[n-1];
    if (bp_x[i] == q) return bp_y[i];
    if (i == 0) return bp_y[0];
    xlo = bp_x[i-1];
    xhi = bp_x[i];
    if (cfg_interp == btint_pkg::IMODE_LINEAR)
      return lerp_y(q, xlo, xhi, bp_y[i-1], bp_y[i]);
    if (cfg_interp == btint_pkg::IMODE_NEAREST)
      return ((q - xlo) <= (xhi - q)) ? bp_y[i-1] : bp_y[i];
    return bp_y[i-1];
  endfunction

  function automatic btint_pkg::out_item_t answer_for(btint_pkg::in_item_t it);
    btint_pkg::out_item_t r;
    if (it.op == btint_pkg::OP_WRITE) begin
      bp_x[it.point_index] = it.x_value;
      bp_y[it.point_index] = it.y_value;
      r.result_value = '0;
      r.status = btint_pkg::STATUS_WRITE_ACK;
    end else begin
      r.result_value = table_lookup($signed(it.x_value));
      r.status = btint_pkg::STATUS_QUERY;
    end
    return r;
  endfunction

  function automatic longint rand_span(longint a, longint b);
    logic [63:0] w;
    w = b - a + 1;
    return a + $signed({$urandom, $urandom} % w);
  endfunction

  // sender
  always @(negedge clk) begin
    drv_valid = in_valid;
    drv_item = in_data;
    if (rst) begin
      drv_valid = 1'b0;
    end else begin
      if (in_valid && in_taken) drv_valid = 1'b0;
      if (!drv_valid && queued_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = queued_items.pop_front();
        drv_valid = 1'b1;
      end
    end
    in_valid <= drv_valid;
    in_data <= drv_item;
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_asks != hold_grants) begin
      hold_grants++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // transaction monitor, checker and watchdog
  always @(posedge clk) begin
    in_taken = !rst && in_valid && in_ready;
    if (in_taken) awaited_answers.push_back(answer_for(in_data));
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (awaited_answers.size() == 0) begin
        $error("output transaction with nothing expected: result_value %0d status %0b",
               out_data.result_value, out_data.status);
        fail_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (out_data.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d", want.result_value,
                 out_data.result_value);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, out_data.status);
          fail_count++;
        end
      end
      idle_cycles = 0;
    end else if (in_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push_write(int idx, longint x, longint y);
    btint_pkg::in_item_t it;
    it.op = btint_pkg::OP_WRITE;
    it.point_index = idx[5:0];
    it.x_value = x[31:0];
    it.y_value = y[31:0];
    plan_x[idx] = $signed(it.x_value);
    queued_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_query(longint x);
    btint_pkg::in_item_t it;
    it.op = btint_pkg::OP_QUERY;
    it.point_index = 6'($urandom_range(63));
    it.x_value = clip32(x);
    it.y_value = $urandom;
    queued_items.push_back(it);
    items_queued++;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      btint_pkg::REG_INTERP: cfg_interp = val[1:0];
      btint_pkg::REG_BOUNDS: cfg_bounds = val[0];
      btint_pkg::REG_COUNT:  cfg_count = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait until every queued transaction has produced its result
  task automatic settle();
    while (results_seen < items_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ascending x over slots 0..n-1 with random spacing
  task automatic build_table(int n);
    longint step_max, slack, cur;
    int k;
    case ($urandom_range(3))
      0: step_max = 4 * Q_ONE;
      1: step_max = 64'sh1_0000_0000 / (n + 1);
      2: step_max = 16;
      default: step_max = 64'sh100_0000;
    endcase
    slack = 64'sd4294967295 - (n - 1) * step_max;
    cur = S32_MIN + rand_span(0, slack);
    for (k = 0; k < n; k++) begin
      push_write(k, cur, $urandom_range(1) ? longint'($signed($urandom))
                                           : rand_span(-16 * Q_ONE, 16 * Q_ONE));
      cur += rand_span(1, step_max);
    end
  endtask

  task automatic plan_query(int n);
    int k;
    longint a, b;
    k = $urandom_range(n - 2);
    a = (plan_x[k] < plan_x[k+1]) ? plan_x[k] : plan_x[k+1];
    b = (plan_x[k] < plan_x[k+1]) ? plan_x[k+1] : plan_x[k];
    case ($urandom_range(9))
      0: push_query($signed($urandom));
      1: push_query(plan_x[0] - rand_span(1, 4 * Q_ONE));
      2: push_query(plan_x[n-1] + rand_span(1, 4 * Q_ONE));
      3: push_query(plan_x[$urandom_range(n - 1)]);
      4: push_query((a + b) >>> 1);
      default: push_query(rand_span(a, b));
    endcase
  endtask

  int count_plan [PHASES] = '{2, 9, 127, 1, 33, 64, 0, 17, 64, 4, 48, 3};

  initial begin
    int ph, k, n, r;
    logic rebuilt;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // two points spanning the whole signed range, reset settings
    push_write(0, S32_MIN, S32_MAX);
    push_write(1, S32_MAX, S32_MIN);
    push_query(S32_MIN);
    push_query(S32_MAX);
    push_query(0);
    push_query(-1);
    settle();

    // nearest mode, clamp: out of range both sides, ties go low
    reg_write(btint_pkg::REG_COUNT, 3);
    reg_write(btint_pkg::REG_INTERP, btint_pkg::IMODE_NEAREST);
    push_write(0, -Q_ONE, 'h100);
    push_write(1, 0, 'h300);
    push_write(2, 3 * Q_ONE, -'h500);
    push_query(-2 * Q_ONE);
    push_query(4 * Q_ONE);
    push_query(-Q_ONE / 2);
    push_query(-Q_ONE / 2 + 1);
    push_query(0);
    settle();

    // interp mode three behaves as lower; wrap above and below the span
    reg_write(btint_pkg::REG_INTERP, 2'd3);
    reg_write(btint_pkg::REG_BOUNDS, btint_pkg::BMODE_WRAP);
    push_query(5 * Q_ONE);
    push_query(S32_MIN);
    push_query(2 * Q_ONE);
    settle();

    // wrap with empty span falls back to clamp; then x[0] above x[n-1]
    reg_write(btint_pkg::REG_INTERP, btint_pkg::IMODE_LINEAR);
    push_write(2, -Q_ONE, 'h700);
    push_query(2 * Q_ONE);
    push_query(-3 * Q_ONE);
    push_write(2, -2 * Q_ONE, 'h700);
    push_query(-3 * Q_ONE / 2);
    push_query(Q_ONE);
    push_write(63, S32_MAX, S32_MAX);
    settle();
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      n = count_plan[ph];
      reg_write(btint_pkg::REG_INTERP, ph % 4);
      reg_write(btint_pkg::REG_BOUNDS, (ph / 2) % 2);
      reg_write(btint_pkg::REG_COUNT, n);
      if (n < 2) n = 2;
      if (n > MAX_PTS) n = MAX_PTS;
      build_table(n);
      rebuilt = 1'b0;
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        r = $urandom_range(99);
        if (r < 80) begin
          plan_query(n);
        end else if (r < 92) begin
          // stray write: may land inside the active range and break the ordering
          push_write($urandom_range(63), $signed($urandom), $signed($urandom));
        end else if (!rebuilt && n <= 17) begin
          build_table(n);
          rebuilt = 1'b1;
        end else begin
          plan_query(n);
        end
      end
      if (ph == 4) hold_asks++;
      settle();
    end

    settle();
    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0 && awaited_answers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== breakpoint_table_interpolator_core.f =====
sv/btint_pkg.sv
sv/btint_div.sv
sv/btint_ctrl.sv
sv/btint_dp.sv
sv/breakpoint_table_interpolator_core.sv
tb/sv/tb_breakpoint_table_interpolator_core.sv
